@@ rtl/nns_pkg.sv @@
package nns_pkg;

   // sizing of the reference set
   localparam int MAX_POINTS = 1024;
   localparam int DIMENSIONS = 3;
   localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int COUNT_W    = $clog2(MAX_POINTS + 1);

   // field widths
   localparam int REQ_W     = 2;
   localparam int COORD_W   = 24;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int DIST_W    = 52;
   localparam int MATCH_W   = 10;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD  = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   // one stored reference point
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clear;
      logic start;
      logic publish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic busy;
      logic out_free;
   } status_type;

endpackage

@@ rtl/nearest_neighbor_search_core.sv @@
// Brute-force nearest-neighbour search over up to MAX_POINTS stored reference points
// (2 or 3 dimensions, signed 24-bit coordinates). A load transaction stores one point
// while the store is not full, a clear transaction empties the set, and each takes no
// result. A query transaction scans the stored points one per cycle through a
// five-stage read, difference, square, sum and compare pipeline; the single read
// port of the reference store sets that rate. The result reports the lowest index
// at the smallest squared distance, and while it waits to be taken the block still
// accepts loads and clears. The tolerance is written through csr_wr_en and
// csr_wr_data; the user must write it only while the block is idle, as the block
// itself does not enforce this.
module nearest_neighbor_search_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [nns_pkg::REQ_W-1:0]           req_type,
   input  logic signed [nns_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [nns_pkg::COORD_W-1:0]  req_coord_y,
   input  logic signed [nns_pkg::COORD_W-1:0]  req_coord_z,
   input  logic                                req_batch_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [nns_pkg::MATCH_W-1:0]         rsp_match_index,
   output logic [nns_pkg::DIST_W-1:0]          rsp_best_distance,
   output logic                                rsp_over_tolerance,
   output logic                                rsp_set_empty,
   output logic                                rsp_last_match,
   input  logic                                csr_wr_en,
   input  logic [nns_pkg::DIST_W-1:0]          csr_wr_data
);
   import nns_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing
   nns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .cmd       (cmd),
      .status    (status)
   );

   // store, distance pipeline and result register
   nns_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .req_coord_z        (req_coord_z),
      .req_batch_end      (req_batch_end),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_match_index    (rsp_match_index),
      .rsp_best_distance  (rsp_best_distance),
      .rsp_over_tolerance (rsp_over_tolerance),
      .rsp_set_empty      (rsp_set_empty),
      .rsp_last_match     (rsp_last_match)
   );

endmodule

@@ rtl/nns_ctrl.sv @@
module nns_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [nns_pkg::REQ_W-1:0]     req_type,
   output nns_pkg::cmd_type              cmd,
   input  nns_pkg::status_type           status
);
   import nns_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_type)
                  REQ_LOAD:  cmd.load  = 1'b1;
                  REQ_CLEAR: cmd.clear = 1'b1;
                  REQ_QUERY: begin
                     cmd.start = 1'b1;
                     state_in  = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (!status.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/nns_datapath.sv @@
module nns_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  nns_pkg::cmd_type                    cmd,
   output nns_pkg::status_type                 status,
   input  logic signed [nns_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [nns_pkg::COORD_W-1:0]  req_coord_y,
   input  logic signed [nns_pkg::COORD_W-1:0]  req_coord_z,
   input  logic                                req_batch_end,
   input  logic                                csr_wr_en,
   input  logic [nns_pkg::DIST_W-1:0]          csr_wr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [nns_pkg::MATCH_W-1:0]         rsp_match_index,
   output logic [nns_pkg::DIST_W-1:0]          rsp_best_distance,
   output logic                                rsp_over_tolerance,
   output logic                                rsp_set_empty,
   output logic                                rsp_last_match
);
   import nns_pkg::*;

   // reference store, no reset
   point_type mem [MAX_POINTS];

   logic [DIST_W-1:0]  tol_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               wr_en;

   point_type          query_ff;
   logic               last_ff;

   logic               scan_active_ff;
   logic [COUNT_W-1:0] rd_addr_ff;
   logic               rd_en;

   // pipeline stages
   point_type          rd_data_ff;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IDX_W-1:0]   idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [DIFF_W-1:0]  abs_x_ff, abs_y_ff, abs_z_ff;
   logic [DIFF_W-1:0]  abs_x_in, abs_y_in, abs_z_in;
   logic signed [DIFF_W-1:0] diff_x, diff_y, diff_z;
   logic [SQ_W-1:0]    sq_x_ff, sq_y_ff, sq_z_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic [DIST_W-1:0]  dist_in;

   logic [DIST_W-1:0]  best_ff;
   logic [IDX_W-1:0]   best_idx_ff;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // point count, loads beyond capacity dropped
   assign wr_en = cmd.load && (count_ff < COUNT_W'(MAX_POINTS));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (wr_en) begin
         count_ff <= count_ff + COUNT_W'(1);
      end
   end

   // store write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= '{x: req_coord_x, y: req_coord_y, z: req_coord_z};
      end
   end

   // query capture
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         query_ff <= '{x: req_coord_x, y: req_coord_y, z: req_coord_z};
         last_ff  <= req_batch_end;
      end
   end

   // scan address sequencer
   assign rd_en = scan_active_ff && (rd_addr_ff != count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_active_ff <= 1'b0;
         rd_addr_ff     <= '0;
      end else if (cmd.start) begin
         scan_active_ff <= 1'b1;
         rd_addr_ff     <= '0;
      end else if (scan_active_ff) begin
         if (rd_en) begin
            rd_addr_ff <= rd_addr_ff + COUNT_W'(1);
         end else begin
            scan_active_ff <= 1'b0;
         end
      end
   end

   // registered store read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr_ff[IDX_W-1:0]];
      end
   end

   // per-axis absolute differences
   assign diff_x = {rd_data_ff.x[COORD_W-1], rd_data_ff.x} - {query_ff.x[COORD_W-1], query_ff.x};
   assign diff_y = {rd_data_ff.y[COORD_W-1], rd_data_ff.y} - {query_ff.y[COORD_W-1], query_ff.y};
   assign diff_z = {rd_data_ff.z[COORD_W-1], rd_data_ff.z} - {query_ff.z[COORD_W-1], query_ff.z};

   assign abs_x_in = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
   assign abs_y_in = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
   assign abs_z_in = diff_z[DIFF_W-1] ? DIFF_W'(-diff_z) : DIFF_W'(diff_z);

   // sum of squares
   always_comb begin
      dist_in = DIST_W'(sq_x_ff) + DIST_W'(sq_y_ff);
      if (DIMENSIONS >= 3) begin
         dist_in = dist_in + DIST_W'(sq_z_ff);
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      idx1_ff  <= rd_addr_ff[IDX_W-1:0];
      idx2_ff  <= idx1_ff;
      idx3_ff  <= idx2_ff;
      idx4_ff  <= idx3_ff;
      abs_x_ff <= abs_x_in;
      abs_y_ff <= abs_y_in;
      abs_z_ff <= abs_z_in;
      sq_x_ff  <= SQ_W'(abs_x_ff) * SQ_W'(abs_x_ff);
      sq_y_ff  <= SQ_W'(abs_y_ff) * SQ_W'(abs_y_ff);
      sq_z_ff  <= SQ_W'(abs_z_ff) * SQ_W'(abs_z_ff);
      dist_ff  <= dist_in;
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // running minimum, first index wins ties
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         best_ff     <= DIST_MAX;
         best_idx_ff <= '0;
      end else if (v4_ff && (dist_ff < best_ff)) begin
         best_ff     <= dist_ff;
         best_idx_ff <= idx4_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_match_index    <= MATCH_W'(best_idx_ff);
         rsp_best_distance  <= best_ff;
         rsp_over_tolerance <= best_ff > tol_ff;
         rsp_set_empty      <= count_ff == '0;
         rsp_last_match     <= last_ff;
      end
   end

   // status back to the controller
   assign status.busy     = scan_active_ff | v1_ff | v2_ff | v3_ff | v4_ff;
   assign status.out_free = !rsp_valid || rsp_ready;

endmodule

@@ rtl/nns_checker.sv @@
module nns_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [nns_pkg::REQ_W-1:0]           req_type,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [nns_pkg::MATCH_W-1:0]         rsp_match_index,
   input logic [nns_pkg::DIST_W-1:0]          rsp_best_distance,
   input logic                                rsp_set_empty
);
   import nns_pkg::*;

   // no result straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_distance)
         && $stable(rsp_match_index))
      else $error("stalled result changed");

   // a query keeps the block busy for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == REQ_QUERY) |=> !req_ready)
      else $error("query accepted with no scan");

   // empty set gives index zero at the maximum distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_set_empty |-> (rsp_best_distance == DIST_MAX) && (rsp_match_index == '0))
      else $error("empty set result wrong");

   // a real match is below the bound of three squared differences
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_set_empty |-> rsp_best_distance[DIST_W-1:DIST_W-2] == 2'b00)
      else $error("match distance out of range");

endmodule

bind nearest_neighbor_search_core nns_checker u_checker (.*);
